// File: hw/rtl/tcw_pkg.sv
// Shared constants and controller/datapath interface types of the text console writer.
package tcw_pkg;

  localparam int COLUMNS = 80;
  localparam int ROWS    = 25;
  localparam int CELLS   = ROWS * COLUMNS;
  localparam int ROW_W   = 5;
  localparam int COL_W   = 7;
  localparam int ADDR_W  = $clog2(CELLS);
  localparam int TAB_W   = 8;

  localparam logic [7:0] RESET_ATTR = 8'h07;
  localparam logic [7:0] SPACE_CHAR = 8'h20;
  localparam logic [7:0] CH_NL      = 8'd10;
  localparam logic [7:0] CH_CR      = 8'd13;
  localparam logic [7:0] CH_TAB     = 8'd9;

  typedef struct packed {
    logic load;
    logic clr_step;
    logic rd_issue;
    logic lf;
    logic cr;
    logic wr_cell;
    logic blank_step;
    logic out_load;
  } tcw_cmd_t;

  typedef struct packed {
    logic clr_last;
    logic is_read;
    logic is_nl;
    logic is_cr;
    logic is_tab;
    logic col_last;
    logic at_bottom;
    logic tab_last;
    logic blank_last;
    logic out_free;
  } tcw_status_t;

endpackage

// File: hw/rtl/text_console_writer.sv
// Top level of the text console writer: configuration port, controller and datapath.
//
// Input items arrive on the s_ stream: s_tuser selects a put (0) or a cell read (1), and
// s_tdata carries the character byte and the row and column of the cell to read. Each item
// gives one result on the m_ stream with the cell read (zero for a put) and the cursor.
// Scrolling moves a row offset and blanks one row with the current attribute, so no row is
// copied. The attribute register sits at APB address 0; pready is always high.
// One item is handled at a time by the controller sequencer. From acceptance to a valid
// result: a return or non-scrolling newline passes DECODE and FINISH, a read DECODE, RD_WAIT
// and FINISH, a plain character DECODE, WRITE and FINISH, and a tab stays in WRITE up to the tab stop.
// A scroll adds the BLANK state before FINISH, with one memory write per cell of the blanked row.
// The next item is accepted in the cycle after the result is loaded into the output register.
// After reset a clearing pass writes all 2000 cells, one per cycle, before s_tready rises;
// configuration writes are taken during it. The cursor and the row offset return to zero.
// While the receiver stalls, the result waits in the output register and a new item may
// still be accepted and worked on until its own result needs that register.
module text_console_writer (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [23:0] s_tdata,  // char_code[7:0], read_row[12:8], read_col[19:13], zeros
  input  logic        s_tuser,  // action
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [31:0] m_tdata,  // cell_value[15:0], cursor_row[20:16], cursor_col[27:21]
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import tcw_pkg::*;

  logic [7:0]  text_attr;
  tcw_cmd_t    cmd;
  tcw_status_t st;

  assign pready = 1'b1;
  assign prdata = (paddr == 3'd0) ? {24'h000000, text_attr} : 32'h00000000;

  always_ff @(posedge clk) begin
    if (rst) text_attr <= RESET_ATTR;
    else if (psel && penable && pwrite && (paddr == 3'd0)) text_attr <= pwdata[7:0];
  end

  tcw_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_tvalid),
    .in_ready (s_tready),
    .st       (st),
    .cmd      (cmd)
  );

  tcw_datapath u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .st        (st),
    .text_attr (text_attr),
    .in_data   (s_tdata),
    .in_user   (s_tuser),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_data  (m_tdata)
  );

  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("item accepted while another is being handled");

  a_cursor_bounds: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tdata[20:16] < ROW_W'(ROWS)) && (m_tdata[27:21] < COL_W'(COLUMNS)))
    else $error("cursor outside the console");

  a_reset_quiet: assert property (@(posedge clk)
    rst |=> !m_tvalid && !s_tready)
    else $error("handshake active right after reset");

endmodule

// File: hw/rtl/tcw_datapath.sv
// Datapath of the text console writer: cell memory, cursor, scroll offset and output register.
module tcw_datapath (
  input  logic                clk,
  input  logic                rst,
  input  tcw_pkg::tcw_cmd_t   cmd,
  output tcw_pkg::tcw_status_t st,
  input  logic [7:0]          text_attr,
  input  logic [23:0]         in_data,
  input  logic                in_user,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [31:0]         out_data
);
  import tcw_pkg::*;

  logic [15:0]       mem [CELLS];
  logic [15:0]       rd_data;
  logic              item_read;
  logic [7:0]        item_char;
  logic [ROW_W-1:0]  item_row;
  logic [COL_W-1:0]  item_col;
  logic [ROW_W-1:0]  cur_row;
  logic [COL_W-1:0]  cur_col;
  logic [ROW_W-1:0]  top_row;
  logic [COL_W-1:0]  blank_col;
  logic [ADDR_W-1:0] clr_addr;
  logic [15:0]       out_cell;
  logic [ROW_W-1:0]  out_row;
  logic [COL_W-1:0]  out_col;

  logic              range_ok;
  logic              we;
  logic [ADDR_W-1:0] waddr;
  logic [ADDR_W-1:0] raddr;
  logic [15:0]       wdata;
  logic              line_adv;

  function automatic logic [ROW_W-1:0] phys_row(input logic [ROW_W-1:0] lrow,
                                                input logic [ROW_W-1:0] top);
    logic [ROW_W:0] s;
    s = {1'b0, lrow} + {1'b0, top};
    if (s >= (ROW_W + 1)'(ROWS)) s = s - (ROW_W + 1)'(ROWS);
    return s[ROW_W-1:0];
  endfunction

  function automatic logic [ADDR_W-1:0] cell_addr(input logic [ROW_W-1:0] prow,
                                                  input logic [COL_W-1:0] col);
    return ADDR_W'(32'(prow) * 32'(COLUMNS) + 32'(col));
  endfunction

  assign range_ok = (item_row < ROW_W'(ROWS)) && (item_col < COL_W'(COLUMNS));
  assign line_adv = cmd.lf || (cmd.wr_cell && st.col_last);

  assign st.clr_last   = (clr_addr == ADDR_W'(CELLS - 1));
  assign st.is_read    = item_read;
  assign st.is_nl      = (item_char == CH_NL);
  assign st.is_cr      = (item_char == CH_CR);
  assign st.is_tab     = (item_char == CH_TAB);
  assign st.col_last   = (cur_col == COL_W'(COLUMNS - 1));
  assign st.at_bottom  = (cur_row == ROW_W'(ROWS - 1));
  assign st.tab_last   = ((cur_col & COL_W'(TAB_W - 1)) == COL_W'(TAB_W - 1));
  assign st.blank_last = (blank_col == COL_W'(COLUMNS - 1));
  assign st.out_free   = !out_valid || out_ready;

  always_comb begin
    we    = cmd.clr_step || cmd.wr_cell || cmd.blank_step;
    waddr = clr_addr;
    wdata = {RESET_ATTR, SPACE_CHAR};
    if (cmd.wr_cell) begin
      waddr = cell_addr(phys_row(cur_row, top_row), cur_col);
      wdata = {text_attr, st.is_tab ? SPACE_CHAR : item_char};
    end else if (cmd.blank_step) begin
      waddr = cell_addr(phys_row(ROW_W'(ROWS - 1), top_row), blank_col);
      wdata = {text_attr, SPACE_CHAR};
    end
    raddr = range_ok ? cell_addr(phys_row(item_row, top_row), item_col) : '0;
  end

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    if (cmd.rd_issue) rd_data <= mem[raddr];
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      item_read <= in_user;
      item_char <= in_data[7:0];
      item_row  <= in_data[12:8];
      item_col  <= in_data[19:13];
    end
    if (cmd.out_load) begin
      out_cell <= (item_read && range_ok) ? rd_data : 16'h0000;
      out_row  <= cur_row;
      out_col  <= cur_col;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cur_row   <= '0;
      cur_col   <= '0;
      top_row   <= '0;
      blank_col <= '0;
      clr_addr  <= '0;
      out_valid <= 1'b0;
    end else begin
      if (cmd.clr_step) clr_addr <= clr_addr + 1'b1;
      if (cmd.cr) cur_col <= '0;
      if (cmd.wr_cell && !st.col_last) cur_col <= cur_col + 1'b1;
      if (line_adv) begin
        cur_col <= '0;
        if (st.at_bottom) begin
          top_row   <= (top_row == ROW_W'(ROWS - 1)) ? '0 : top_row + 1'b1;
          blank_col <= '0;
        end else begin
          cur_row <= cur_row + 1'b1;
        end
      end
      if (cmd.blank_step) blank_col <= blank_col + 1'b1;
      if (cmd.out_load) out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
    end
  end

  assign out_data = {4'h0, out_col, out_row, out_cell};

endmodule

// File: hw/rtl/tcw_ctrl.sv
// Controller state machine of the text console writer.
module tcw_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  tcw_pkg::tcw_status_t st,
  output tcw_pkg::tcw_cmd_t    cmd
);
  import tcw_pkg::*;

  typedef enum logic [2:0] {
    S_CLEAR, S_IDLE, S_DECODE, S_RD_WAIT, S_WRITE, S_BLANK, S_FINISH
  } state_t;

  state_t state, state_next;

  assign in_ready = (state == S_IDLE);

  always_comb begin
    cmd        = '0;
    state_next = state;
    case (state)
      S_CLEAR: begin
        cmd.clr_step = 1'b1;
        if (st.clr_last) state_next = S_IDLE;
      end
      S_IDLE: begin
        cmd.load = in_valid;
        if (in_valid) state_next = S_DECODE;
      end
      S_DECODE: begin
        if (st.is_read) begin
          cmd.rd_issue = 1'b1;
          state_next   = S_RD_WAIT;
        end else if (st.is_nl) begin
          cmd.lf     = 1'b1;
          state_next = st.at_bottom ? S_BLANK : S_FINISH;
        end else if (st.is_cr) begin
          cmd.cr     = 1'b1;
          state_next = S_FINISH;
        end else begin
          state_next = S_WRITE;
        end
      end
      S_RD_WAIT: state_next = S_FINISH;
      S_WRITE: begin
        cmd.wr_cell = 1'b1;
        if (st.col_last) state_next = st.at_bottom ? S_BLANK : S_FINISH;
        else if (!st.is_tab || st.tab_last) state_next = S_FINISH;
      end
      S_BLANK: begin
        cmd.blank_step = 1'b1;
        if (st.blank_last) state_next = S_FINISH;
      end
      S_FINISH: begin
        if (st.out_free) begin
          cmd.out_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= S_CLEAR;
    else state <= state_next;
  end

endmodule
